// ----- rtl/lap2d_pkg.sv -----
// Shared types and constants for the five-point Laplacian stencil unit.
`timescale 1ns / 1ps

package lap2d_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int LAP_BITS   = 39;
	localparam int CFG_BITS   = 11;
	localparam int CFG_ADDR_BITS = 2;
	localparam int MAX_HEIGHT = 1024;
	localparam int ROW_BITS   = 10;
	localparam int H_BITS     = 11;
	localparam int SY_BITS    = 2 * ROW_BITS;
	localparam int MIN_DIM    = 3;

	localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

	typedef struct packed {
		logic has_lap;
		logic has_zero;
		logic last;
	} res_flags_t;

endpackage

// ----- rtl/lap2d_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lap2d_ram #(
	parameter int WIDTH = lap2d_pkg::DEF_SAMPLE_BITS,
	parameter int DEPTH = lap2d_pkg::DEF_MAX_WIDTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/lap2d_window.sv -----
// Grid position tracking, row buffers and second differences of the stencil.
`timescale 1ns / 1ps

module lap2d_window #(
	parameter int MAX_WIDTH   = lap2d_pkg::DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = lap2d_pkg::DEF_SAMPLE_BITS,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int DW = $clog2(MAX_WIDTH + 1),
	localparam int DB = SAMPLE_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [DW-1:0]                 width_use,
	input  logic [lap2d_pkg::H_BITS-1:0]  height_use,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          diff_valid,
	input  logic                          diff_ready,
	output logic signed [DB-1:0]          dx,
	output logic signed [DB-1:0]          dy,
	output lap2d_pkg::res_flags_t         res_flags
);

	typedef struct packed {
		logic has_lap;
		logic interior;
		logic use_left;
		logic use_right;
		logic use_up;
		logic use_down;
		logic has_zero;
		logic last;
	} pos_flags_t;

	logic [AW-1:0]                  col_q;
	logic [lap2d_pkg::ROW_BITS-1:0] row_q;
	logic                           accept;
	logic                           col_last;
	logic                           row_last;
	logic [DW:0]                    col_x;
	logic [DW:0]                    w_x;
	logic [lap2d_pkg::H_BITS:0]     row_x;
	logic [lap2d_pkg::H_BITS:0]     h_x;
	pos_flags_t                     pos_c;
	logic [AW-1:0]                  prev_raddr;

	logic                           valid_s1;
	logic signed [SAMPLE_BITS-1:0]  sample_s1;
	logic [AW-1:0]                  col_s1;
	pos_flags_t                     pos_s1;
	logic                           s1_adv;
	logic                           s2_free;

	logic signed [SAMPLE_BITS-1:0]  here_q;
	logic signed [SAMPLE_BITS-1:0]  left_q;
	logic [SAMPLE_BITS-1:0]         prev_rd;
	logic [SAMPLE_BITS-1:0]         old_rd;

	logic signed [DB-1:0]           left_v;
	logic signed [DB-1:0]           right_v;
	logic signed [DB-1:0]           ctr_v;
	logic signed [DB-1:0]           up_v;
	logic signed [DB-1:0]           down_v;
	logic signed [DB-1:0]           dx_c;
	logic signed [DB-1:0]           dy_c;

	logic                           valid_s2;
	logic signed [DB-1:0]           dx_s2;
	logic signed [DB-1:0]           dy_s2;
	lap2d_pkg::res_flags_t          res_s2;

	assign accept   = in_valid && in_ready;
	assign col_x    = (DW + 1)'(col_q);
	assign w_x      = (DW + 1)'(width_use);
	assign row_x    = (lap2d_pkg::H_BITS + 1)'(row_q);
	assign h_x      = (lap2d_pkg::H_BITS + 1)'(height_use);
	assign col_last = (col_x + (DW + 1)'(1)) == w_x;
	assign row_last = (row_x + (lap2d_pkg::H_BITS + 1)'(1)) == h_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + lap2d_pkg::ROW_BITS'(1);
				end
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	always_comb begin
		pos_c.has_lap   = row_q != '0;
		pos_c.interior  = (row_x >= (lap2d_pkg::H_BITS + 1)'(2)) && (col_q != '0)
			&& ((col_x + (DW + 1)'(2)) <= w_x);
		pos_c.use_left  = col_x >= (DW + 1)'(2);
		pos_c.use_right = (col_x + (DW + 1)'(3)) <= w_x;
		pos_c.use_up    = row_x >= (lap2d_pkg::H_BITS + 1)'(3);
		pos_c.use_down  = (row_x + (lap2d_pkg::H_BITS + 1)'(2)) <= h_x;
		pos_c.has_zero  = row_last;
		pos_c.last      = col_last;
	end

	// fetch the next column of the previous row; wrap to the head of the row
	assign prev_raddr = col_last ? '0 : col_q + AW'(1);

	assign s2_free  = !valid_s2 || diff_ready;
	assign s1_adv   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			col_s1    <= col_q;
			pos_s1    <= pos_c;
		end
		if (s1_adv) begin
			left_q <= here_q;
			here_q <= $signed(prev_rd);
		end
	end

	lap2d_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WIDTH)
	) u_prev_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata(sample_s1),
		.re   (accept),
		.raddr(prev_raddr),
		.rdata(prev_rd)
	);

	lap2d_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WIDTH)
	) u_old_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata(here_q),
		.re   (accept),
		.raddr(col_q),
		.rdata(old_rd)
	);

	always_comb begin
		ctr_v   = DB'(here_q);
		left_v  = pos_s1.use_left  ? DB'(left_q) : '0;
		right_v = pos_s1.use_right ? DB'($signed(prev_rd)) : '0;
		up_v    = pos_s1.use_up    ? DB'($signed(old_rd)) : '0;
		down_v  = pos_s1.use_down  ? DB'(sample_s1) : '0;
		if (pos_s1.interior) begin
			dx_c = left_v + right_v - (ctr_v + ctr_v);
			dy_c = up_v + down_v - (ctr_v + ctr_v);
		end else begin
			dx_c = '0;
			dy_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			dx_s2           <= dx_c;
			dy_s2           <= dy_c;
			res_s2.has_lap  <= pos_s1.has_lap;
			res_s2.has_zero <= pos_s1.has_zero;
			res_s2.last     <= pos_s1.last;
		end
	end

	assign diff_valid = valid_s2;
	assign dx         = dx_s2;
	assign dy         = dy_s2;
	assign res_flags  = res_s2;

endmodule

// ----- rtl/lap2d_scale.sv -----
// Scaling of the second differences, final sum and result output stage.
`timescale 1ns / 1ps

module lap2d_scale #(
	parameter int MAX_WIDTH   = lap2d_pkg::DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = lap2d_pkg::DEF_SAMPLE_BITS,
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int SXW = 2 * AW,
	localparam int DB  = SAMPLE_BITS + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [SXW-1:0]                    scale_x,
	input  logic [lap2d_pkg::SY_BITS-1:0]     scale_y,
	input  logic                              diff_valid,
	output logic                              diff_ready,
	input  logic signed [DB-1:0]              dx,
	input  logic signed [DB-1:0]              dy,
	input  lap2d_pkg::res_flags_t             res_flags,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lap2d_pkg::LAP_BITS-1:0] laplacian,
	output logic                              frame_end
);

	localparam int PXB = DB + SXW + 1;
	localparam int PYB = DB + lap2d_pkg::SY_BITS + 1;

	logic                                   valid_s3;
	logic signed [PXB-1:0]                  px_s3;
	logic signed [PYB-1:0]                  py_s3;
	lap2d_pkg::res_flags_t                  res_s3;
	logic                                   s3_has;
	logic                                   s3_adv;
	logic                                   s3_free;
	logic signed [PXB-1:0]                  px_c;
	logic signed [PYB-1:0]                  py_c;

	logic                                   lap_pend_q;
	logic                                   zero_pend_q;
	logic                                   last_q;
	logic signed [lap2d_pkg::LAP_BITS-1:0]  lap_q;
	logic                                   out_free;
	logic                                   out_load;

	assign px_c = dx * $signed({1'b0, scale_x});
	assign py_c = dy * $signed({1'b0, scale_y});

	assign s3_has     = res_s3.has_lap || res_s3.has_zero;
	assign out_free   = !out_valid || (out_ready && !(lap_pend_q && zero_pend_q));
	assign s3_adv     = valid_s3 && (!s3_has || out_free);
	assign s3_free    = !valid_s3 || s3_adv;
	assign out_load   = valid_s3 && s3_has && out_free;
	assign diff_ready = s3_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= diff_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (diff_valid && s3_free) begin
			px_s3  <= px_c;
			py_s3  <= py_c;
			res_s3 <= res_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lap_pend_q  <= 1'b0;
			zero_pend_q <= 1'b0;
		end else if (out_load) begin
			lap_pend_q  <= res_s3.has_lap;
			zero_pend_q <= res_s3.has_zero;
		end else if (out_valid && out_ready) begin
			if (lap_pend_q) begin
				lap_pend_q <= 1'b0;
			end else begin
				zero_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			lap_q  <= lap2d_pkg::LAP_BITS'(px_s3) + lap2d_pkg::LAP_BITS'(py_s3);
			last_q <= res_s3.last;
		end
	end

	assign out_valid = lap_pend_q || zero_pend_q;
	assign laplacian = lap_pend_q ? lap_q : '0;
	assign frame_end = !lap_pend_q && last_q;

endmodule

// ----- rtl/laplace_stencil_2d_unit.sv -----
// Top level of the streamed five-point Laplacian stencil unit.
// Takes one sample per cycle in row-major order, unless the output stalls,
// and returns the scaled five-point Laplacian of each grid point one row
// later, zero on the boundary. Two row buffers of MAX_WIDTH entries each do
// one write and one read per cycle, so one item can be taken every cycle;
// items of the last row give two results each, and input waits while both
// are pending. The row buffers need no clearing after reset. A write to
// grid_width or grid_height restarts the frame.
`timescale 1ns / 1ps

module laplace_stencil_2d_unit #(
	parameter int MAX_WIDTH   = lap2d_pkg::DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = lap2d_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lap2d_pkg::CFG_ADDR_BITS-1:0]   cfg_index,
	input  logic [lap2d_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [lap2d_pkg::LAP_BITS-1:0] laplacian,
	output logic                                  frame_end
);

	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DW  = $clog2(MAX_WIDTH + 1);
	localparam int SXW = 2 * AW;
	localparam int DB  = SAMPLE_BITS + 2;
	localparam int EW  = (DW > lap2d_pkg::CFG_BITS) ? DW : lap2d_pkg::CFG_BITS;

	logic [lap2d_pkg::CFG_BITS-1:0]   grid_width_q;
	logic [lap2d_pkg::CFG_BITS-1:0]   grid_height_q;
	logic                             restart;
	logic [EW-1:0]                    w_ext;
	logic [EW-1:0]                    w_clamp;
	logic [DW-1:0]                    width_use;
	logic [lap2d_pkg::H_BITS-1:0]     height_use;
	logic [AW-1:0]                    wm1;
	logic [lap2d_pkg::ROW_BITS-1:0]   hm1;
	logic [SXW-1:0]                   scale_x_q;
	logic [lap2d_pkg::SY_BITS-1:0]    scale_y_q;

	logic                             diff_valid;
	logic                             diff_ready;
	logic signed [DB-1:0]             dx;
	logic signed [DB-1:0]             dy;
	lap2d_pkg::res_flags_t            res_flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lap2d_pkg::CFG_BITS'(1024);
			grid_height_q <= lap2d_pkg::CFG_BITS'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lap2d_pkg::REG_GRID_WIDTH: begin
					grid_width_q <= cfg_data;
				end
				lap2d_pkg::REG_GRID_HEIGHT: begin
					grid_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign restart = cfg_we && ((cfg_index == lap2d_pkg::REG_GRID_WIDTH)
		|| (cfg_index == lap2d_pkg::REG_GRID_HEIGHT));

	always_comb begin
		w_ext = EW'(grid_width_q);
		if (w_ext < EW'(lap2d_pkg::MIN_DIM)) begin
			w_clamp = EW'(lap2d_pkg::MIN_DIM);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_clamp = EW'(MAX_WIDTH);
		end else begin
			w_clamp = w_ext;
		end
		if (grid_height_q < lap2d_pkg::CFG_BITS'(lap2d_pkg::MIN_DIM)) begin
			height_use = lap2d_pkg::H_BITS'(lap2d_pkg::MIN_DIM);
		end else if (grid_height_q > lap2d_pkg::CFG_BITS'(lap2d_pkg::MAX_HEIGHT)) begin
			height_use = lap2d_pkg::H_BITS'(lap2d_pkg::MAX_HEIGHT);
		end else begin
			height_use = lap2d_pkg::H_BITS'(grid_height_q);
		end
	end

	assign width_use = DW'(w_clamp);
	assign wm1       = AW'(width_use - DW'(1));
	assign hm1       = lap2d_pkg::ROW_BITS'(height_use - lap2d_pkg::H_BITS'(1));

	always_ff @(posedge clk) begin
		scale_x_q <= SXW'(wm1) * SXW'(wm1);
		scale_y_q <= lap2d_pkg::SY_BITS'(hm1) * lap2d_pkg::SY_BITS'(hm1);
	end

	lap2d_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.width_use (width_use),
		.height_use(height_use),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.diff_valid(diff_valid),
		.diff_ready(diff_ready),
		.dx        (dx),
		.dy        (dy),
		.res_flags (res_flags)
	);

	lap2d_scale #(
		.MAX_WIDTH  (MAX_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale_x   (scale_x_q),
		.scale_y   (scale_y_q),
		.diff_valid(diff_valid),
		.diff_ready(diff_ready),
		.dx        (dx),
		.dy        (dy),
		.res_flags (res_flags),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.laplacian (laplacian),
		.frame_end (frame_end)
	);

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for laplace_stencil_2d_unit: directed grids, random grids, then clamped extremes.
`timescale 1ns / 1ps

module tb;

	localparam int SB        = lap2d_pkg::DEF_SAMPLE_BITS;
	localparam int PLAN_LEN  = 29;
	localparam int PIPE_SLACK = 12;
	localparam int HI_SAMPLE = 32767;
	localparam int LO_SAMPLE = -32768;
	localparam longint CENTRE_LO_LAP = 524288;
	localparam longint CENTRE_HI_LAP = -524272;
	localparam logic [lap2d_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [lap2d_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_HI = 2'd3;

	typedef logic signed [SB-1:0] samp_t;
	typedef logic signed [lap2d_pkg::LAP_BITS-1:0] lap_t;

	typedef struct packed {
		lap_t lap;
		logic fend;
	} lap_res_t;

	typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_t;

	typedef struct {
		step_kind_t                          kind;
		logic [lap2d_pkg::CFG_ADDR_BITS-1:0] idx;
		int                                  value;
		bit                                  typed;
		int                                  n_res;
		longint                              lap0;
		bit                                  fend;
	} plan_row_t;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [lap2d_pkg::CFG_ADDR_BITS-1:0] cfg_index = '0;
	logic [lap2d_pkg::CFG_BITS-1:0]      cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	samp_t                               sample_in = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	lap_t                                laplacian;
	logic                                frame_end;

	samp_t line_near [lap2d_pkg::DEF_MAX_WIDTH];
	samp_t line_far [lap2d_pkg::DEF_MAX_WIDTH];
	samp_t near_left;
	int    col_pos;
	int    row_pos;
	int    grid_w;
	int    grid_h;

	lap_res_t  step_res [2];
	int        step_n;
	lap_res_t  lap_due [$];
	plan_row_t plan [PLAN_LEN];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int errors;
	int items_sent;
	int results_seen;
	int frames_seen;
	int reg_writes;

	laplace_stencil_2d_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.laplacian (laplacian),
		.frame_end (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic int fit_dim(input int v, input int hi);
		if (v < lap2d_pkg::MIN_DIM)
			return lap2d_pkg::MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic compute_laplacian(input samp_t s);
		int     w;
		int     h;
		int     c;
		int     r;
		samp_t  here;
		longint centre;
		longint left;
		longint right;
		longint up;
		longint down;
		longint sx;
		longint sy;
		longint lap;
		w = fit_dim(grid_w, lap2d_pkg::DEF_MAX_WIDTH);
		h = fit_dim(grid_h, lap2d_pkg::MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		if (c >= w)
			c = 0;
		if (r >= h)
			r = 0;
		here = line_near[c];
		step_n = 0;
		if (r >= 1) begin
			lap = 0;
			if (r >= 2 && c >= 1 && c + 2 <= w) begin
				centre = here;
				left = (c >= 2) ? near_left : 0;
				right = (c + 3 <= w) ? line_near[c + 1] : 0;
				up = (r >= 3) ? line_far[c] : 0;
				down = (r + 2 <= h) ? s : 0;
				sx = longint'(w - 1) * longint'(w - 1);
				sy = longint'(h - 1) * longint'(h - 1);
				lap = sx * (left - 2 * centre + right) + sy * (up - 2 * centre + down);
			end
			step_res[0] = '{lap[lap2d_pkg::LAP_BITS-1:0], 1'b0};
			step_n = 1;
		end
		if (r + 1 == h) begin
			step_res[step_n] = '{'0, (c + 1 == w)};
			step_n++;
		end
		near_left = here;
		line_far[c] = here;
		line_near[c] = s;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	function automatic samp_t pick_sample();
		case ($urandom_range(9))
			0, 1: return samp_t'($urandom_range(511) - 256);
			2: begin
				case ($urandom_range(3))
					0: return samp_t'(HI_SAMPLE);
					1: return samp_t'(LO_SAMPLE);
					2: return '0;
					default: return '1;
				endcase
			end
			default: return samp_t'($urandom);
		endcase
	endfunction

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (lap_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lap2d_pkg::CFG_ADDR_BITS-1:0] idx,
			input int value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[lap2d_pkg::CFG_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		if (idx == lap2d_pkg::REG_GRID_WIDTH || idx == lap2d_pkg::REG_GRID_HEIGHT) begin
			if (idx == lap2d_pkg::REG_GRID_WIDTH)
				grid_w = value[lap2d_pkg::CFG_BITS-1:0];
			else
				grid_h = value[lap2d_pkg::CFG_BITS-1:0];
			col_pos = 0;
			row_pos = 0;
			near_left = '0;
		end
	endtask

	task automatic push_sample(input samp_t s, input bit typed, input int n_res,
			input longint lap0, input bit fend);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		compute_laplacian(s);
		if (typed) begin
			step_n = n_res;
			step_res[0] = '{lap0[lap2d_pkg::LAP_BITS-1:0], (n_res == 1) ? fend : 1'b0};
			step_res[1] = '{'0, fend};
		end
		for (int i = 0; i < step_n; i++)
			lap_due.push_back(step_res[i]);
	endtask

	task automatic random_phase(input int budget);
		int wv;
		int hv;
		int cells;
		int count;
		int spare_at;
		int done;
		done = 0;
		while (done < budget) begin
			case ($urandom_range(9))
				0: wv = $urandom_range(lap2d_pkg::MIN_DIM - 1);
				1: wv = $urandom_range(40, 11);
				default: wv = $urandom_range(10, lap2d_pkg::MIN_DIM);
			endcase
			case ($urandom_range(9))
				0: hv = $urandom_range(lap2d_pkg::MIN_DIM - 1);
				1: hv = $urandom_range(20, 9);
				default: hv = $urandom_range(8, lap2d_pkg::MIN_DIM);
			endcase
			write_reg(lap2d_pkg::REG_GRID_WIDTH, wv);
			write_reg(lap2d_pkg::REG_GRID_HEIGHT, hv);
			cells = fit_dim(wv, lap2d_pkg::DEF_MAX_WIDTH)
				* fit_dim(hv, lap2d_pkg::MAX_HEIGHT);
			if ($urandom_range(6) == 0)
				count = $urandom_range(cells - 1, 1);
			else
				count = cells * $urandom_range(2, 1);
			spare_at = ($urandom_range(9) == 0) ? $urandom_range(count - 1, 1) : -1;
			for (int i = 0; i < count; i++) begin
				if (i == spare_at)
					write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
						$urandom_range(2047));
				push_sample(pick_sample(), 1'b0, 0, 0, 1'b0);
			end
			done += count;
		end
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		lap_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (frame_end)
				frames_seen++;
			if (lap_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result at %0t: laplacian %0d frame_end %0b",
						$realtime, laplacian, frame_end);
			end else begin
				want = lap_due.pop_front();
				if (want.lap !== laplacian || want.fend !== frame_end) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at %0t: laplacian exp %0d got %0d, %s %0b got %0b",
							$realtime, want.lap, laplacian, "frame_end exp",
							want.fend, frame_end);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < lap2d_pkg::DEF_MAX_WIDTH; i++) begin
			line_near[i] = '0;
			line_far[i] = '0;
		end
		near_left = '0;
		col_pos = 0;
		row_pos = 0;
		grid_w = lap2d_pkg::DEF_MAX_WIDTH;
		grid_h = lap2d_pkg::MAX_HEIGHT;
		hold_cycles = 0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		frames_seen = 0;
		reg_writes = 0;
		send_idle_pct = 26;
		recv_idle_pct = 62;

		plan = '{
			'{STEP_CFG,  lap2d_pkg::REG_GRID_WIDTH,  0,    0, 0, 0, 0},
			'{STEP_CFG,  lap2d_pkg::REG_GRID_HEIGHT, 2,    0, 0, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 0, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 0, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 0, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 1, 0, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 1, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 1, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 2, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 2, CENTRE_LO_LAP, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 2, 0, 1},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 0, 0, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 0, 0, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 0, 0, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 1, 0, 0},
			'{STEP_ITEM, '0, HI_SAMPLE, 1, 1, 0, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 1, 0, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 2, 0, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 2, CENTRE_HI_LAP, 0},
			'{STEP_ITEM, '0, LO_SAMPLE, 1, 2, 0, 1},
			'{STEP_CFG,  lap2d_pkg::REG_GRID_WIDTH,  1,    0, 0, 0, 0},
			'{STEP_CFG,  lap2d_pkg::REG_GRID_HEIGHT, 1025, 0, 0, 0, 0},
			'{STEP_ITEM, '0, 21845,     0, 0, 0, 0},
			'{STEP_ITEM, '0, -21846,    0, 0, 0, 0},
			'{STEP_ITEM, '0, 1,         0, 0, 0, 0},
			'{STEP_ITEM, '0, -1,        0, 0, 0, 0},
			'{STEP_ITEM, '0, 0,         0, 0, 0, 0},
			'{STEP_ITEM, '0, 256,       0, 0, 0, 0},
			'{STEP_ITEM, '0, -256,      0, 0, 0, 0}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < PLAN_LEN; k++) begin
			if (plan[k].kind == STEP_CFG)
				write_reg(plan[k].idx, plan[k].value);
			else
				push_sample(samp_t'(plan[k].value), plan[k].typed, plan[k].n_res,
					plan[k].lap0, plan[k].fend);
		end

		// hold the output while a full frame keeps coming in
		write_reg(lap2d_pkg::REG_GRID_WIDTH, 5);
		write_reg(lap2d_pkg::REG_GRID_HEIGHT, 8);
		hold_cycles = 300;
		repeat (40) push_sample(pick_sample(), 1'b0, 0, 0, 1'b0);
		random_phase(140);

		send_idle_pct = 62;
		recv_idle_pct = 26;
		random_phase(140);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(140);

		// widest grid, head of the first row
		write_reg(lap2d_pkg::REG_GRID_WIDTH, 2047);
		write_reg(lap2d_pkg::REG_GRID_HEIGHT, lap2d_pkg::MIN_DIM);
		repeat (lap2d_pkg::MIN_DIM * 10) push_sample(pick_sample(), 1'b0, 0, 0, 1'b0);
		// tallest grid, first rows only
		write_reg(lap2d_pkg::REG_GRID_WIDTH, lap2d_pkg::MIN_DIM);
		write_reg(lap2d_pkg::REG_GRID_HEIGHT, lap2d_pkg::MAX_HEIGHT);
		repeat (lap2d_pkg::MIN_DIM * 40) push_sample(pick_sample(), 1'b0, 0, 0, 1'b0);

		drain_results();

		$display("Sent %0d items and checked %0d results across %0d register writes,",
			items_sent, results_seen, reg_writes);
		$display("%0d frames closed; grids from 3x3 up to the width and height clamps, %s",
			frames_seen, "under three idle mixes and a long output stall.");
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lap2d_pkg.sv
rtl/lap2d_ram.sv
rtl/lap2d_window.sv
rtl/lap2d_scale.sv
rtl/laplace_stencil_2d_unit.sv
test/tb.sv
